FILE: src/ghq_pkg.sv
// Package for the ground segment height query block.
// Holds field widths, operation codes and the divider cell record.
// No dependencies.
`default_nettype none

package ghq_pkg;

   localparam int COORD_W          = 24;
   localparam int DIV_W            = 25;
   localparam int PROD_W           = 2 * DIV_W;
   localparam int DIV_STEPS        = DIV_W;
   localparam int ENTRY_W          = 4 * COORD_W;
   localparam int COUNT_W          = 9;
   localparam int MAX_SEGMENTS_DEF = 256;

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_CHAIN = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   typedef struct packed {
      logic                      valid;
      logic                      span;
      logic                      neg;
      logic signed [COORD_W-1:0] y1;
      logic [DIV_W-1:0]          dx;
      logic [DIV_W-1:0]          rem;
      logic [DIV_W-1:0]          num;
      logic [DIV_W-1:0]          quo;
   } div_cell_type;

endpackage

`default_nettype wire

FILE: src/ghq_ram.sv
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
`default_nettype none

module ghq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: src/ghq_div_cell.sv
// One restoring division step of the divider chain.
// Depends on ghq_pkg for the cell record.
`default_nettype none

module ghq_div_cell
   import ghq_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  div_cell_type      cell_i,
   output div_cell_type      cell_o
);

   div_cell_type   cell_ff;
   div_cell_type   cell_in;
   logic [DIV_W:0] trial;

   always_comb begin
      cell_in = cell_i;
      trial   = {cell_i.rem, cell_i.num[DIV_W-1]};
      cell_in.num = {cell_i.num[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, cell_i.dx}) begin
         cell_in.rem = DIV_W'(trial - {1'b0, cell_i.dx});
         cell_in.quo = {cell_i.quo[DIV_W-2:0], 1'b1};
      end else begin
         cell_in.rem = trial[DIV_W-1:0];
         cell_in.quo = {cell_i.quo[DIV_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else begin
         cell_ff <= cell_in;
      end
   end

   assign cell_o = cell_ff;

endmodule

`default_nettype wire

FILE: src/ground_segment_height_query.sv
// Top level of the ground segment height query block.
// Depends on ghq_pkg, ghq_ram and ghq_div_cell.
//
//   Channel   Direction  Signals
//   req_      in         req_valid/req_ready, op, point_x/y, right_x/y
//   rsp_      out        rsp_valid/rsp_ready, hit, ground_y, table_full, count
//   csr_      in         APB-style register port, query_mode at address 0
//
// Add, chained point and clear go from idle through the execute state to the post state.
// A query feeds the stored segments into the pipeline: one segment enters the
// division chain each cycle and the chain of 25 cells sets the fill time.
// Reset clears the count, the pending point and the mode; the table needs no clearing.
// A new transaction is accepted while the previous result waits on the output register.
`default_nettype none

module ground_segment_height_query
   import ghq_pkg::*;
#(
   parameter int MaxSegments = MAX_SEGMENTS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [1:0]                req_op,
   input  wire logic signed [COORD_W-1:0] req_point_x,
   input  wire logic signed [COORD_W-1:0] req_point_y,
   input  wire logic signed [COORD_W-1:0] req_right_x,
   input  wire logic signed [COORD_W-1:0] req_right_y,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic                           rsp_hit,
   output logic signed [COORD_W-1:0]      rsp_ground_y,
   output logic                           rsp_table_full,
   output logic [COUNT_W-1:0]             rsp_segment_count,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [2:0]                csr_paddr,
   input  wire logic [31:0]               csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);

   localparam int AW = (MaxSegments > 1) ? $clog2(MaxSegments) : 1;
   localparam int CW = $clog2(MaxSegments + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EXEC  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_POST  = 3'd4;

   logic [2:0]                state_ff, state_in;
   logic [1:0]                op_ff, op_in;
   logic signed [COORD_W-1:0] px_ff, px_in, py_ff, py_in, rx_ff, rx_in, ry_ff, ry_in;
   logic [CW-1:0]             count_ff, count_in, idx_ff, idx_in;
   logic signed [COORD_W-1:0] pend_x_ff, pend_x_in, pend_y_ff, pend_y_in;
   logic                      mode_ff, mode_in;
   logic                      found_ff, found_in;
   logic signed [COORD_W-1:0] best_ff, best_in;
   logic                      res_hit_ff, res_hit_in, res_full_ff, res_full_in;
   logic signed [COORD_W-1:0] res_gy_ff, res_gy_in;
   logic                      rsp_valid_ff, rsp_valid_in, rsp_hit_ff, rsp_hit_in;
   logic                      rsp_full_ff, rsp_full_in;
   logic signed [COORD_W-1:0] rsp_gy_ff, rsp_gy_in;
   logic [COUNT_W-1:0]        rsp_count_ff, rsp_count_in;

   logic                      wr_en;
   logic [ENTRY_W-1:0]        wr_data;
   logic [ENTRY_W-1:0]        rd_data;
   logic                      rd_valid_ff;

   logic signed [COORD_W-1:0] e_x1, e_y1, e_x2, e_y2;
   logic                      sa_valid_ff, sa_span_ff;
   logic signed [DIV_W-1:0]   sa_dy_ff, sa_dxq_ff;
   logic [DIV_W-1:0]          sa_dx_ff;
   logic signed [COORD_W-1:0] sa_y1_ff;
   logic                      sb_valid_ff, sb_span_ff;
   logic signed [PROD_W-1:0]  sb_prod_ff;
   logic [DIV_W-1:0]          sb_dx_ff;
   logic signed [COORD_W-1:0] sb_y1_ff;
   logic [PROD_W-1:0]         mag;
   div_cell_type              sc_ff, sc_in;
   div_cell_type              chain [DIV_STEPS+1];
   logic [DIV_STEPS-1:0]      cell_busy;
   logic                      busy;
   div_cell_type              fin;
   logic signed [DIV_W:0]     qs;
   logic signed [DIV_W:0]     h_wide;
   logic signed [COORD_W-1:0] h;
   logic                      cfg_wr;

   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {31'd0, mode_ff} : 32'd0;

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_ground_y      = rsp_gy_ff;
   assign rsp_table_full    = rsp_full_ff;
   assign rsp_segment_count = rsp_count_ff;

   ghq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MaxSegments)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign e_x1 = rd_data[4*COORD_W-1:3*COORD_W];
   assign e_y1 = rd_data[3*COORD_W-1:2*COORD_W];
   assign e_x2 = rd_data[2*COORD_W-1:COORD_W];
   assign e_y2 = rd_data[COORD_W-1:0];

   always_ff @(posedge clock) begin
      sa_span_ff <= (e_x1 < px_ff) && (e_x2 > px_ff);
      sa_dy_ff   <= {e_y2[COORD_W-1], e_y2} - {e_y1[COORD_W-1], e_y1};
      sa_dxq_ff  <= {px_ff[COORD_W-1], px_ff} - {e_x1[COORD_W-1], e_x1};
      sa_dx_ff   <= {e_x2[COORD_W-1], e_x2} - {e_x1[COORD_W-1], e_x1};
      sa_y1_ff   <= e_y1;
      sb_span_ff <= sa_span_ff;
      sb_prod_ff <= sa_dy_ff * sa_dxq_ff;
      sb_dx_ff   <= sa_dx_ff;
      sb_y1_ff   <= sa_y1_ff;
      if (reset) begin
         rd_valid_ff    <= 1'b0;
         sa_valid_ff    <= 1'b0;
         sb_valid_ff    <= 1'b0;
         sc_ff          <= '0;
      end else begin
         rd_valid_ff <= (state_ff == ST_SCAN);
         sa_valid_ff <= rd_valid_ff;
         sb_valid_ff <= sa_valid_ff;
         sc_ff       <= sc_in;
      end
   end

   assign mag = sb_prod_ff[PROD_W-1] ? PROD_W'(-sb_prod_ff) : PROD_W'(sb_prod_ff);

   always_comb begin
      sc_in.valid = sb_valid_ff;
      sc_in.span  = sb_span_ff;
      sc_in.neg   = sb_prod_ff[PROD_W-1];
      sc_in.y1    = sb_y1_ff;
      sc_in.dx    = sb_dx_ff;
      sc_in.rem   = mag[PROD_W-1:DIV_W];
      sc_in.num   = mag[DIV_W-1:0];
      sc_in.quo   = '0;
   end

   assign chain[0] = sc_ff;

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
      ghq_div_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .cell_i (chain[i]),
         .cell_o (chain[i+1])
      );
      assign cell_busy[i] = chain[i+1].valid;
   end

   assign busy   = rd_valid_ff || sa_valid_ff || sb_valid_ff || sc_ff.valid || (|cell_busy);
   assign fin    = chain[DIV_STEPS];
   assign qs     = fin.neg ? -$signed({1'b0, fin.quo}) : $signed({1'b0, fin.quo});
   assign h_wide = {{2{fin.y1[COORD_W-1]}}, fin.y1} + qs;
   assign h      = h_wide[COORD_W-1:0];

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      pend_x_in    = pend_x_ff;
      pend_y_in    = pend_y_ff;
      mode_in      = mode_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      res_hit_in   = res_hit_ff;
      res_gy_in    = res_gy_ff;
      res_full_in  = res_full_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_gy_in    = rsp_gy_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_count_in = rsp_count_ff;
      wr_en        = 1'b0;
      wr_data      = {px_ff, py_ff, rx_ff, ry_ff};

      if (cfg_wr && (csr_paddr[2] == 1'b0)) begin
         mode_in = csr_pwdata[0];
      end

      if (fin.valid && fin.span) begin
         if (mode_ff) begin
            found_in = 1'b1;
            best_in  = h;
         end else if ((h > py_ff) && (!found_ff || (h < best_ff))) begin
            found_in = 1'b1;
            best_in  = h;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_op;
               px_in    = req_point_x;
               py_in    = req_point_y;
               rx_in    = req_right_x;
               ry_in    = req_right_y;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_hit_in  = 1'b0;
            res_gy_in   = '0;
            res_full_in = 1'b0;
            state_in    = ST_POST;
            case (op_ff)
               OP_ADD: begin
                  if (count_ff < CW'(MaxSegments)) begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CW'(1);
                  end else begin
                     res_full_in = 1'b1;
                  end
               end
               OP_CHAIN: begin
                  wr_data = {pend_x_ff, pend_y_ff, px_ff, py_ff};
                  if ((pend_x_ff != '0) || (pend_y_ff != '0)) begin
                     if (count_ff < CW'(MaxSegments)) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                     end else begin
                        res_full_in = 1'b1;
                     end
                  end
                  pend_x_in = px_ff;
                  pend_y_in = py_ff;
               end
               OP_QUERY: begin
                  found_in = 1'b0;
                  best_in  = '0;
                  idx_in   = '0;
                  state_in = (count_ff == '0) ? ST_DRAIN : ST_SCAN;
               end
               OP_CLEAR: begin
                  count_in = '0;
               end
               default: begin
                  count_in = count_ff;
               end
            endcase
         end
         ST_SCAN: begin
            idx_in = idx_ff + CW'(1);
            if ((idx_ff + CW'(1)) == count_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!busy) begin
               res_hit_in  = found_ff;
               res_gy_in   = best_ff;
               res_full_in = 1'b0;
               state_in    = ST_POST;
            end
         end
         ST_POST: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = res_hit_ff;
               rsp_gy_in    = res_gy_ff;
               rsp_full_in  = res_full_ff;
               rsp_count_in = COUNT_W'(count_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      rx_ff        <= rx_in;
      ry_ff        <= ry_in;
      idx_ff       <= idx_in;
      best_ff      <= best_in;
      res_hit_ff   <= res_hit_in;
      res_gy_ff    <= res_gy_in;
      res_full_ff  <= res_full_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_gy_ff    <= rsp_gy_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_count_ff <= rsp_count_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_x_ff    <= '0;
         pend_y_ff    <= '0;
         mode_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_x_ff    <= pend_x_in;
         pend_y_ff    <= pend_y_in;
         mode_ff      <= mode_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MaxSegments))
      else $error("Segment count exceeds the table depth.");

   a_read_in_query: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == ST_SCAN) || (state_ff == ST_DRAIN))
      else $error("Table read outside a query scan.");

   a_hit_needs_segment: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POST) && res_hit_ff |-> count_ff != '0)
      else $error("Hit reported with an empty table.");

   a_idle_pipeline: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !busy)
      else $error("Divider chain busy while the block is idle.");
`endif

endmodule

`default_nettype wire
